### hdl/rcsd_pkg.sv
// Shared constants and register indexes for the RC servo pulse decoder.
`default_nettype none

package rcsd_pkg;

  // Width counter; the pulse width field and the arithmetic below assume 16 bits.
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_CENTER = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MAX    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_JITTER_LIMIT = 3'd4;

  // Register reset values
  localparam logic [15:0] PULSE_MIN_RST    = 16'd1000;
  localparam logic [15:0] PULSE_CENTER_RST = 16'd1500;
  localparam logic [15:0] PULSE_MAX_RST    = 16'd2000;
  localparam logic [7:0]  DEAD_ZONE_RST    = 8'd10;
  localparam logic [7:0]  JITTER_LIMIT_RST = 8'd2;

  // Mapping constants
  localparam int PCT_HI      = 100;
  localparam int PCT_LO      = -100;
  localparam int PCT_SPAN    = 100;
  localparam int DEG_HI      = 180;
  localparam int DEG_UP_BASE = 91;
  localparam int DEG_SPAN    = 89;
  localparam int DEG_MID     = 90;

  // Divider: quotient bits (top bit flags a quotient of 512 or more)
  localparam int Q_BITS  = 10;
  localparam int MAG_W   = COUNT_BITS + 7;   // |(x-a)*100| < 2^23
  localparam int DEN_W   = 16;
  localparam int CMP_W   = DEN_W + Q_BITS;
  localparam int STEP_W  = 4;

endpackage

`default_nettype wire

### hdl/rcsd_if.sv
// Valid/ready channel interfaces for the RC servo pulse decoder.
`default_nettype none

interface rcsd_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic position_taken;

  modport source (output valid, output pin_level, output position_taken, input ready);
  modport sink   (input valid, input pin_level, input position_taken, output ready);
endinterface

interface rcsd_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       pulse_width_us;
  logic signed [7:0] percent;
  logic [7:0]        degrees;

  modport source (output valid, output pulse_width_us, output percent, output degrees,
                  input ready);
  modport sink   (input valid, input pulse_width_us, input percent, input degrees,
                  output ready);
endinterface

`default_nettype wire

### hdl/rc_servo_pulse_decoder_top.sv
// RC servo pulse decoder: edge tracking, shared restoring divider, clamp and jitter hold.
//
//   channel   dir   beat contents
//   in_if     in    pin_level, position_taken (one beat per microsecond tick)
//   out_if    out   pulse_width_us, percent, degrees
//   cfg       in    cfg_we_i, cfg_addr_i, cfg_wdata_i (write only)
//
// A tick with no completed pulse leaves the sequencer idle. A tick that ends a pulse runs
// the sequencer: one divider pass per value, each a setup step, ten shift-subtract steps of
// the one divider and a finish step, then a load into the output register; a pass
// with nothing to divide (dead zone, center or empty span) skips the ten steps.
// in_if.ready is low while the sequencer runs, and a finished result holds it low while
// the output register is still full.
// Reset is asynchronous and clears control state, configuration and held values to their defaults.
`default_nettype none

module rc_servo_pulse_decoder_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  rcsd_in_if.sink                          in_if,
  rcsd_out_if.source                       out_if,
  input  wire                              cfg_we_i,
  input  wire [rcsd_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire [rcsd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import rcsd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // Configuration registers
  logic [15:0] min_q, mid_q, max_q;
  logic [7:0]  dz_q, jit_q;

  // Edge tracking state
  logic                  level_q, armed_q, pend_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic signed [7:0]     held_pct_q;
  logic [7:0]            held_deg_q;

  // Sequencer and divider state
  logic [2:0]              state_q;
  logic                    sel_q;       // 0 percent, 1 degrees
  logic [COUNT_BITS-1:0]   x_q;
  logic [MAG_W-1:0]        rem_q;
  logic [DEN_W-1:0]        den_q;
  logic [Q_BITS-1:0]       quo_q;
  logic [STEP_W-1:0]       step_q;
  logic                    neg_q;
  logic signed [7:0]       ofs_q;

  // Output register
  logic              ov_q;
  logic [15:0]       pw_q;
  logic signed [7:0] pct_q;
  logic [7:0]        deg_q;

  logic in_acc, pend_n, fire;

  // Setup path signals
  logic [16:0]        x_e, mid_e, dz_e;
  logic               pct_up, pct_lo, deg_up, deg_lo, seg_up, seg_lo;
  logic signed [17:0] x_s, a_s, b_s, diff_s, den_s, den_abs;
  logic signed [7:0]  k_s, ofs_n;
  logic signed [25:0] num_s, num_abs;
  logic               skip;

  // Divider step signals
  logic [CMP_W-1:0] cmp_v, rem_ext, rem_sub;
  logic             ge;

  // Finish path signals
  logic [9:0]         mag10;
  logic signed [11:0] sq_s, v_s, lo_b, hi_b, vc_s, held_e, dlt_s, adlt_s;
  logic               take;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;
  assign pend_n      = in_if.position_taken ? 1'b0 : pend_q;
  assign fire        = in_acc & ~in_if.pin_level & level_q & armed_q & ~pend_n;

  assign out_if.valid          = ov_q;
  assign out_if.pulse_width_us = pw_q;
  assign out_if.percent        = pct_q;
  assign out_if.degrees        = deg_q;

  // Segment choice and scaled numerator for the map in progress
  always_comb begin
    x_e    = {1'b0, x_q};
    mid_e  = {1'b0, mid_q};
    dz_e   = {9'd0, dz_q};
    pct_up = (x_e >= mid_e + dz_e);
    pct_lo = (x_e + dz_e <= mid_e);
    deg_up = (x_e > mid_e);
    deg_lo = (x_e < mid_e);
    seg_up = sel_q ? deg_up : pct_up;
    seg_lo = sel_q ? deg_lo : pct_lo;
    x_s    = signed'({2'b00, x_q});
    a_s    = seg_up ? signed'({2'b00, mid_q}) : signed'({2'b00, min_q});
    b_s    = seg_up ? signed'({2'b00, max_q}) : signed'({2'b00, mid_q});
    diff_s = x_s - a_s;
    den_s  = b_s - a_s;
    k_s    = sel_q ? 8'(DEG_SPAN) : 8'(PCT_SPAN);
    num_s  = 26'(diff_s) * 26'(k_s);
    num_abs = num_s[25] ? -num_s : num_s;
    den_abs = den_s[17] ? -den_s : den_s;
    skip    = ~(seg_up | seg_lo) | (den_s == 18'sd0);
    if (seg_up) begin
      ofs_n = sel_q ? 8'(DEG_UP_BASE) : 8'sd0;
    end else if (seg_lo) begin
      ofs_n = sel_q ? 8'sd0 : 8'(PCT_LO);
    end else begin
      ofs_n = sel_q ? 8'(DEG_MID) : 8'sd0;
    end
  end

  // One shift-subtract step of the restoring divider
  always_comb begin
    cmp_v   = CMP_W'(den_q) << step_q;
    rem_ext = CMP_W'(rem_q);
    ge      = (rem_ext >= cmp_v);
    rem_sub = rem_ext - cmp_v;
  end

  // Sign, offset, clamp and jitter hold
  always_comb begin
    mag10  = quo_q[Q_BITS-1] ? 10'd511 : {1'b0, quo_q[Q_BITS-2:0]};
    sq_s   = neg_q ? -signed'({2'b00, mag10}) : signed'({2'b00, mag10});
    v_s    = sq_s + 12'(ofs_q);
    lo_b   = sel_q ? 12'sd0 : 12'(PCT_LO);
    hi_b   = sel_q ? 12'(DEG_HI) : 12'(PCT_HI);
    if (v_s < lo_b) begin
      vc_s = lo_b;
    end else if (v_s > hi_b) begin
      vc_s = hi_b;
    end else begin
      vc_s = v_s;
    end
    held_e = sel_q ? signed'({4'd0, held_deg_q}) : 12'(held_pct_q);
    dlt_s  = vc_s - held_e;
    adlt_s = dlt_s[11] ? -dlt_s : dlt_s;
    take   = (unsigned'(adlt_s) >= {4'd0, jit_q});
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= PULSE_MIN_RST;
      mid_q <= PULSE_CENTER_RST;
      max_q <= PULSE_MAX_RST;
      dz_q  <= DEAD_ZONE_RST;
      jit_q <= JITTER_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PULSE_MIN:    min_q <= cfg_wdata_i;
        REG_PULSE_CENTER: mid_q <= cfg_wdata_i;
        REG_PULSE_MAX:    max_q <= cfg_wdata_i;
        REG_DEAD_ZONE:    dz_q  <= cfg_wdata_i[7:0];
        REG_JITTER_LIMIT: jit_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Edge tracking, width counter and pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      armed_q <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (in_acc) begin
      level_q <= in_if.pin_level;
      pend_q  <= fire ? 1'b1 : pend_n;
      if (in_if.pin_level && !level_q) begin
        armed_q <= 1'b1;
        cnt_q   <= COUNT_BITS'(1);
      end else if (in_if.pin_level && level_q) begin
        if (armed_q && cnt_q != COUNT_MAX) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (fire) begin
        armed_q <= 1'b0;
      end
    end
  end

  // Sequencer around the shared divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sel_q      <= 1'b0;
      step_q     <= '0;
      held_pct_q <= 8'sd0;
      held_deg_q <= 8'(DEG_MID);
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (fire) begin
            sel_q   <= 1'b0;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          step_q  <= STEP_W'(Q_BITS - 1);
          state_q <= skip ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_FIN: begin
          if (take) begin
            if (sel_q) begin
              held_deg_q <= vc_s[7:0];
            end else begin
              held_pct_q <= vc_s[7:0];
            end
          end
          if (sel_q) begin
            state_q <= ST_OUT;
          end else begin
            sel_q   <= 1'b1;
            state_q <= ST_SETUP;
          end
        end
        ST_OUT: begin
          if (!ov_q || out_if.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= cnt_q;
    end
    if (state_q == ST_SETUP) begin
      rem_q <= num_abs[MAG_W-1:0];
      den_q <= den_abs[DEN_W-1:0];
      neg_q <= num_s[25] ^ den_s[17];
      ofs_q <= ofs_n;
      quo_q <= '0;
    end else if (state_q == ST_DIV && ge) begin
      rem_q         <= rem_sub[MAG_W-1:0];
      quo_q[step_q] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == ST_OUT && (!ov_q || out_if.ready)) begin
      ov_q <= 1'b1;
    end else if (out_if.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!ov_q || out_if.ready)) begin
      pw_q  <= x_q;
      pct_q <= held_pct_q;
      deg_q <= held_deg_q;
    end
  end

  // Checks
  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (!armed_q && pend_q && state_q == ST_SETUP))
    else $error("falling edge result did not disarm and set pending");

  a_busy_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> pend_q)
    else $error("divider busy without a pending position");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_pct_q >= 8'(PCT_LO) && held_pct_q <= 8'(PCT_HI)))
    else $error("held percent out of range");

  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_deg_q <= 8'(DEG_HI)))
    else $error("held degrees out of range");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> ($past(state_q) == ST_OUT))
    else $error("result register loaded outside the output step");

endmodule

`default_nettype wire
